### rtl/weighted_semaphore_wait_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted semaphore wait queue
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_SEMAPHORE_WAIT_QUEUE_TOP_MACROS_SVH
`define WEIGHTED_SEMAPHORE_WAIT_QUEUE_TOP_MACROS_SVH

`ifndef SYNTH
// checked only while out of reset
`define WSQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wsq assertion failed");
// checked at every edge, reset included
`define WSQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("wsq assertion failed");
`else
`define WSQ_ASSERT(lbl, clk, rst_n, prop)
`define WSQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/wsq_pkg.sv
// ----------------------------------------------------------------------------
// wsq_pkg
// Types, constants and helpers shared by the semaphore wait queue modules.
// ----------------------------------------------------------------------------
package wsq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CAP_W       = 5;
    localparam int CMP_W       = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
    localparam int CAP_RESET   = (QUEUE_DEPTH < 16) ? QUEUE_DEPTH : 16;
    localparam int TASK_W      = 4;
    localparam int AMT_W       = 8;
    localparam int CNT_W       = 16;
    localparam int INIT_W      = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CAPACITY = 1'b1;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_FULL    = 3'd2,
        ST_NO_WAKE = 3'd3,
        ST_WOKE    = 3'd4
    } status_t;

    typedef enum logic {
        REQ_WAIT   = 1'b0,
        REQ_SIGNAL = 1'b1
    } req_type_t;

    typedef struct packed {
        logic              req_type;
        logic [TASK_W-1:0] task_id;
        logic [AMT_W-1:0]  amount;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [TASK_W-1:0]        woken_task;
        logic signed [CNT_W-1:0]  count_now;
    } res_t;

    typedef struct packed {
        logic clear;
        logic cap_we;
        logic push;
        logic pop;
    } ring_ctrl_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [TASK_W-1:0] front_task;
        logic [AMT_W-1:0]  front_amount;
    } ring_stat_t;

    function automatic logic [IDX_W-1:0] ring_next(
        input logic [IDX_W-1:0] idx,
        input logic [CAP_W-1:0] cap
    );
        logic [CMP_W-1:0] n;
        n = CMP_W'(idx) + CMP_W'(1);
        if (n >= CMP_W'(cap)) begin
            ring_next = '0;
        end else begin
            ring_next = n[IDX_W-1:0];
        end
    endfunction

    function automatic logic signed [CNT_W-1:0] sat_cnt(input logic signed [CNT_W:0] v);
        if (v[CNT_W] != v[CNT_W-1]) begin
            sat_cnt = v[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
        end else begin
            sat_cnt = v[CNT_W-1:0];
        end
    endfunction

endpackage

### rtl/weighted_semaphore_wait_queue_top.sv
// ----------------------------------------------------------------------------
// weighted_semaphore_wait_queue_top
// Weighted counting semaphore with a FIFO ring of blocked waiters.
// ----------------------------------------------------------------------------
// One request can be taken per clock cycle. A request accepted at a clock edge
// is held in the input register until the execute stage takes it, and its
// result is then presented from the result register. A result held by
// m_ready low stalls the execute stage, and s_ready drops once the input
// register also holds a request. The execute stage updates both counts and
// the ring pointers as it takes each request, so back-to-back requests see
// each other's effects. A wait
// lowers the count and blocks into the ring when it goes negative (status
// full when the ring has no room); a signal raises both counts and wakes the
// front waiter when the free amount covers it. Counts saturate at 16 bits.
// Writing either config register reloads both counts from initial_count and
// empties the ring; write only while no request is in flight.
// ----------------------------------------------------------------------------
`include "weighted_semaphore_wait_queue_top_macros.svh"

module weighted_semaphore_wait_queue_top import wsq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  req_t                   s_req,
    output logic                   m_valid,
    input  logic                   m_ready,
    output res_t                   m_res,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic                    req_valid;
    req_t                    req;
    logic                    fire;
    ring_ctrl_t              ring_ctrl;
    ring_stat_t              ring_stat;

    logic [INIT_W-1:0]       init_reg;
    logic [INIT_W-1:0]       init_next;
    logic signed [CNT_W-1:0] sem_reg;
    logic signed [CNT_W-1:0] sem_next;
    logic signed [CNT_W-1:0] free_reg;
    logic signed [CNT_W-1:0] free_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    res_t                    res_reg;
    res_t                    res_next;

    logic signed [CNT_W:0]   amt_ext;
    logic signed [CNT_W:0]   need_ext;
    logic signed [CNT_W-1:0] sem_lowered;
    logic signed [CNT_W-1:0] sem_raised;
    logic signed [CNT_W-1:0] free_lowered;
    logic signed [CNT_W-1:0] free_raised;
    logic signed [CNT_W-1:0] free_popped;
    logic                    can_wake;
    logic                    reload;

    wsq_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .take      (fire),
        .req_valid (req_valid),
        .req       (req)
    );

    wsq_ring u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ring_ctrl),
        .cap_wdata   (cfg_wdata[CAP_W-1:0]),
        .push_task   (req.task_id),
        .push_amount (req.amount),
        .stat        (ring_stat)
    );

    assign fire   = req_valid && (!m_valid_reg || m_ready);
    assign reload = cfg_we && (cfg_index == REG_INITIAL_COUNT || cfg_index == REG_QUEUE_CAPACITY);

    assign amt_ext      = signed'({{(CNT_W + 1 - AMT_W){1'b0}}, req.amount});
    assign need_ext     = signed'({{(CNT_W + 1 - AMT_W){1'b0}}, ring_stat.front_amount});
    assign sem_lowered  = sat_cnt({sem_reg[CNT_W-1], sem_reg} - amt_ext);
    assign sem_raised   = sat_cnt({sem_reg[CNT_W-1], sem_reg} + amt_ext);
    assign free_lowered = sat_cnt({free_reg[CNT_W-1], free_reg} - amt_ext);
    assign free_raised  = sat_cnt({free_reg[CNT_W-1], free_reg} + amt_ext);
    assign free_popped  = sat_cnt({free_raised[CNT_W-1], free_raised} - need_ext);
    // task ids are 4 bits wide, so every front entry names a valid task
    assign can_wake     = !ring_stat.empty &&
                          (signed'({free_raised[CNT_W-1], free_raised}) >= need_ext);

    always_comb begin
        init_next           = init_reg;
        sem_next            = sem_reg;
        free_next           = free_reg;
        ring_ctrl           = '0;
        res_next            = res_reg;
        m_valid_next        = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (reload) begin
            ring_ctrl.clear  = 1'b1;
            ring_ctrl.cap_we = (cfg_index == REG_QUEUE_CAPACITY);
            if (cfg_index == REG_INITIAL_COUNT) begin
                init_next = cfg_wdata[INIT_W-1:0];
            end
            sem_next  = signed'({{(CNT_W - INIT_W){1'b0}}, init_next});
            free_next = signed'({{(CNT_W - INIT_W){1'b0}}, init_next});
        end else if (fire) begin
            m_valid_next        = 1'b1;
            res_next.woken_task = '0;
            if (req.req_type == REQ_WAIT) begin
                if (sem_lowered[CNT_W-1]) begin
                    if (ring_stat.full) begin
                        res_next.status = ST_FULL;
                    end else begin
                        sem_next        = sem_lowered;
                        ring_ctrl.push  = 1'b1;
                        res_next.status = ST_BLOCKED;
                    end
                end else begin
                    sem_next        = sem_lowered;
                    free_next       = free_lowered;
                    res_next.status = ST_GRANTED;
                end
            end else begin
                sem_next = sem_raised;
                if (can_wake) begin
                    ring_ctrl.pop       = 1'b1;
                    free_next           = free_popped;
                    res_next.woken_task = ring_stat.front_task;
                    res_next.status     = ST_WOKE;
                end else begin
                    free_next       = free_raised;
                    res_next.status = ST_NO_WAKE;
                end
            end
            res_next.count_now = sem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg    <= '0;
            sem_reg     <= '0;
            free_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            init_reg    <= init_next;
            sem_reg     <= sem_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

    `WSQ_ASSERT(a_woken_zero, aclk, aresetn, (m_valid && m_res.status != ST_WOKE) |-> (m_res.woken_task == '0))
    `WSQ_ASSERT(a_granted_nonneg, aclk, aresetn, (m_valid && m_res.status == ST_GRANTED) |-> !m_res.count_now[CNT_W-1])
    `WSQ_ASSERT(a_blocked_neg, aclk, aresetn, (m_valid && m_res.status == ST_BLOCKED) |-> m_res.count_now[CNT_W-1])
    `WSQ_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid)

endmodule

### rtl/wsq_in_reg.sv
// ----------------------------------------------------------------------------
// wsq_in_reg
// Input register: holds one request until the execute stage takes it.
// ----------------------------------------------------------------------------
module wsq_in_reg import wsq_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    input  logic take,
    output logic req_valid,
    output req_t req
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

### rtl/wsq_ring.sv
// ----------------------------------------------------------------------------
// wsq_ring
// Ring of waiting tasks: entry storage, head/tail pointers and capacity.
// ----------------------------------------------------------------------------
`include "weighted_semaphore_wait_queue_top_macros.svh"

module wsq_ring import wsq_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ring_ctrl_t            ctrl,
    input  logic [CAP_W-1:0]      cap_wdata,
    input  logic [TASK_W-1:0]     push_task,
    input  logic [AMT_W-1:0]      push_amount,
    output ring_stat_t            stat
);

    logic [TASK_W-1:0] waiter_task_reg   [QUEUE_DEPTH];
    logic [AMT_W-1:0]  waiter_amount_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  tail_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [CAP_W-1:0]  cap_next;
    logic [IDX_W-1:0]  tail_adv;

    assign tail_adv = ring_next(tail_reg, cap_reg);

    always_comb begin
        cap_next = cap_reg;
        if (ctrl.cap_we) begin
            if (cap_wdata < CAP_W'(2)) begin
                cap_next = CAP_W'(2);
            end else if (CMP_W'(cap_wdata) > CMP_W'(QUEUE_DEPTH)) begin
                cap_next = CAP_W'(QUEUE_DEPTH);
            end else begin
                cap_next = cap_wdata;
            end
        end
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctrl.clear) begin
            head_next = '0;
            tail_next = '0;
        end else begin
            if (ctrl.push) begin
                tail_next = tail_adv;
            end
            if (ctrl.pop) begin
                head_next = ring_next(head_reg, cap_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cap_reg  <= CAP_W'(CAP_RESET);
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cap_reg  <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push && !ctrl.clear) begin
            waiter_task_reg[tail_reg]   <= push_task;
            waiter_amount_reg[tail_reg] <= push_amount;
        end
    end

    assign stat.empty        = (head_reg == tail_reg);
    assign stat.full         = (tail_adv == head_reg);
    assign stat.front_task   = waiter_task_reg[head_reg];
    assign stat.front_amount = waiter_amount_reg[head_reg];

    `WSQ_ASSERT(a_push_pop_excl, aclk, aresetn, !(ctrl.push && ctrl.pop))
    `WSQ_ASSERT(a_no_push_full, aclk, aresetn, ctrl.push |-> !stat.full)
    `WSQ_ASSERT(a_no_pop_empty, aclk, aresetn, ctrl.pop |-> !stat.empty)
    `WSQ_ASSERT(a_clear_empties, aclk, aresetn, ctrl.clear |=> stat.empty)
    `WSQ_ASSERT(a_ptr_in_range, aclk, aresetn, (CMP_W'(tail_reg) < CMP_W'(cap_reg)) && (CMP_W'(head_reg) < CMP_W'(cap_reg)))

endmodule
